// File: rtl/rtt_pkg.sv
// Shared constants and types for the request timeout tracker.
package rtt_pkg;

   localparam int ID_W           = 6;
   localparam int SPAN_W         = 32;
   localparam int EVT_TIME_W     = 32;
   localparam int DEF_NUM_IDS    = 64;
   localparam int DEF_TIME_WIDTH = 32;
   localparam logic [SPAN_W-1:0] SPAN_RESET = SPAN_W'(3);

   localparam logic ACT_START = 1'b0;
   localparam logic ACT_END   = 1'b1;

   typedef struct packed {
      logic            pop;     // drop head, whole row shifts down
      logic            apply;   // remove matching id and/or append
      logic            del_en;  // removal of a matching id is allowed
      logic            add_en;  // append new entry at the tail
      logic [ID_W-1:0] id;
   } cell_cmd_type;

endpackage

// File: rtl/rtt_cell.sv
// One slot of the ordered request row: id, start stamp and occupancy.
module rtt_cell import rtt_pkg::*; #(
   parameter int TIME_WIDTH = DEF_TIME_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cell_cmd_type          cmd,
   input  logic [TIME_WIDTH-1:0] new_stamp,
   input  logic                  prev_valid,
   input  logic                  up_valid,
   input  logic [ID_W-1:0]       up_id,
   input  logic [TIME_WIDTH-1:0] up_stamp,
   input  logic                  found_in,
   input  logic                  found_all,
   output logic                  found_out,
   output logic                  valid,
   output logic [ID_W-1:0]       id,
   output logic [TIME_WIDTH-1:0] stamp
);

   logic                  valid_ff, valid_in;
   logic [ID_W-1:0]       id_ff, id_in;
   logic [TIME_WIDTH-1:0] stamp_ff, stamp_in;
   logic                  match, shift, add;

   always_comb begin
      match     = valid_ff && (id_ff == cmd.id) && cmd.del_en;
      found_out = found_in | match;
      shift     = cmd.pop | (cmd.apply & found_out);
      // tail slot: last occupied one if a removal compacts the row, else first free one
      add       = cmd.apply & cmd.add_en &
                  (found_all ? (valid_ff & ~up_valid) : (~valid_ff & prev_valid));
      valid_in  = valid_ff;
      id_in     = id_ff;
      stamp_in  = stamp_ff;
      if (add) begin
         valid_in = 1'b1;
         id_in    = cmd.id;
         stamp_in = new_stamp;
      end else if (shift) begin
         valid_in = up_valid;
         id_in    = up_id;
         stamp_in = up_stamp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      id_ff    <= id_in;
      stamp_ff <= stamp_in;
   end

   assign valid = valid_ff;
   assign id    = id_ff;
   assign stamp = stamp_ff;

endmodule

// File: rtl/request_timeout_tracker.sv
// Request timeout tracker: a row of NUM_IDS cells holds outstanding requests oldest first.
// An accepted event first pops every expired request it reveals from the head cell, one
// entry a cycle while the result side is ready (a stall holds the pop), and the start/end
// action is then applied to the whole row at once. An expired request is reported when its
// start stamp lies more than timeout_span below the event time; the last report of an event
// carries tlast.
module request_timeout_tracker import rtt_pkg::*; #(
   parameter int NUM_IDS    = DEF_NUM_IDS,
   parameter int TIME_WIDTH = DEF_TIME_WIDTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [39:0]       req_tdata,   // event_id[5:0], event_time[37:6], zero[39:38]
   input  logic              req_tuser,   // action: 0 start, 1 end
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [39:0]       rsp_tdata,   // expired_id[5:0], detected_at[37:6], zero[39:38]
   output logic              rsp_tlast,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [SPAN_W-1:0] csr_data     // timeout_span
);

   localparam int CMP_W = (TIME_WIDTH > SPAN_W) ? TIME_WIDTH : SPAN_W;

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   state_type             state_ff;
   logic                  act_ff;
   logic [ID_W-1:0]       id_ff;
   logic [TIME_WIDTH-1:0] now_ff;
   logic [SPAN_W-1:0]     span_ff;
   logic                  rsp_valid_ff;
   logic [ID_W-1:0]       rsp_id_ff;
   logic [EVT_TIME_W-1:0] rsp_time_ff;
   logic                  rsp_last_ff;

   logic                  valid_w [NUM_IDS];
   logic [ID_W-1:0]       id_w    [NUM_IDS];
   logic [TIME_WIDTH-1:0] stamp_w [NUM_IDS];
   logic                  found_w [NUM_IDS+1];

   cell_cmd_type          cmd;
   logic                  head_exp, second_exp, out_free, id_ok;
   logic [TIME_WIDTH-1:0] diff0, diff1;

   assign out_free = ~rsp_valid_ff | rsp_tready;
   assign id_ok    = 32'(id_ff) < NUM_IDS;

   always_comb begin
      diff0      = now_ff - stamp_w[0];
      diff1      = now_ff - stamp_w[1];
      head_exp   = valid_w[0] && (now_ff >= stamp_w[0]) &&
                   (CMP_W'(diff0) > CMP_W'(span_ff));
      second_exp = valid_w[1] && (now_ff >= stamp_w[1]) &&
                   (CMP_W'(diff1) > CMP_W'(span_ff));
      cmd.pop    = (state_ff == ST_RUN) & head_exp & out_free;
      cmd.apply  = (state_ff == ST_RUN) & ~head_exp;
      cmd.del_en = id_ok;
      cmd.add_en = id_ok & (act_ff == ACT_START);
      cmd.id     = id_ff;
   end

   assign found_w[0] = 1'b0;

   for (genvar i = 0; i < NUM_IDS; i++) begin : g_cell
      logic                  up_valid;
      logic [ID_W-1:0]       up_id;
      logic [TIME_WIDTH-1:0] up_stamp;
      logic                  prev_valid;

      if (i == NUM_IDS - 1) begin : g_end
         assign up_valid = 1'b0;
         assign up_id    = id_w[i];
         assign up_stamp = stamp_w[i];
      end else begin : g_mid
         assign up_valid = valid_w[i+1];
         assign up_id    = id_w[i+1];
         assign up_stamp = stamp_w[i+1];
      end
      if (i == 0) begin : g_first
         assign prev_valid = 1'b1;
      end else begin : g_rest
         assign prev_valid = valid_w[i-1];
      end

      rtt_cell #(.TIME_WIDTH(TIME_WIDTH)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .new_stamp  (now_ff),
         .prev_valid (prev_valid),
         .up_valid   (up_valid),
         .up_id      (up_id),
         .up_stamp   (up_stamp),
         .found_in   (found_w[i]),
         .found_all  (found_w[NUM_IDS]),
         .found_out  (found_w[i+1]),
         .valid      (valid_w[i]),
         .id         (id_w[i]),
         .stamp      (stamp_w[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         span_ff      <= SPAN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            span_ff <= csr_data;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (!head_exp) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
         if (cmd.pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (state_ff == ST_IDLE && req_tvalid) begin
         act_ff <= req_tuser;
         id_ff  <= req_tdata[ID_W-1:0];
         now_ff <= TIME_WIDTH'(req_tdata[ID_W +: EVT_TIME_W]);
      end
      if (cmd.pop) begin
         rsp_id_ff   <= id_w[0];
         rsp_time_ff <= EVT_TIME_W'(now_ff);
         rsp_last_ff <= ~second_exp;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_time_ff, rsp_id_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: rtl/rtt_checker.sv
// Port-level checks for the request timeout tracker, bound to the top level.
module rtt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat pending after reset");

   a_one_event: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second event taken before the first was applied");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("timeout report without an event in progress");

endmodule

bind request_timeout_tracker rtt_checker u_rtt_checker (.*);

// File: test/request_timeout_tracker_test.sv
// Self-checking testbench for request_timeout_tracker: directed table, random event phases.
module request_timeout_tracker_test;
   import rtt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                  act;
      logic [ID_W-1:0]       id;
      logic [EVT_TIME_W-1:0] at;
      logic                  typed;    // expectation written in the row
      logic                  hit;      // one report expected
      logic [ID_W-1:0]       hit_id;
   } event_row_type;

   typedef struct packed {
      logic [ID_W-1:0]       id;
      logic [EVT_TIME_W-1:0] at;
      logic                  last;
   } report_type;

   typedef struct packed {
      logic [ID_W-1:0]       id;
      logic [EVT_TIME_W-1:0] stamp;
   } pending_type;

   localparam int NUM_ROWS = 20;

   // Typed rows assume the reset span of 3.
   localparam event_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      '{ACT_START, 6'd0,  32'd0,          1'b1, 1'b0, 6'd0},
      '{ACT_START, 6'd63, 32'd1,          1'b1, 1'b0, 6'd0},
      '{ACT_END,   6'd5,  32'd2,          1'b1, 1'b0, 6'd0},   // end of unknown id
      '{ACT_START, 6'd1,  32'd3,          1'b1, 1'b0, 6'd0},   // age equals span
      '{ACT_END,   6'd63, 32'd4,          1'b1, 1'b1, 6'd0},
      '{ACT_START, 6'd1,  32'd5,          1'b1, 1'b0, 6'd0},   // repeated start
      '{ACT_END,   6'd7,  32'd8,          1'b1, 1'b0, 6'd0},
      '{ACT_START, 6'd2,  32'd9,          1'b1, 1'b1, 6'd1},
      '{ACT_START, 6'd3,  32'd9,          1'b0, 1'b0, 6'd0},
      '{ACT_START, 6'd4,  32'd10,         1'b0, 1'b0, 6'd0},
      '{ACT_START, 6'd5,  32'd2,          1'b0, 1'b0, 6'd0},   // time goes backwards
      '{ACT_START, 6'd6,  32'd13,         1'b0, 1'b0, 6'd0},
      '{ACT_END,   6'd6,  32'd20,         1'b0, 1'b0, 6'd0},
      '{ACT_END,   6'd6,  32'd30,         1'b1, 1'b0, 6'd0},   // empty list
      '{ACT_START, 6'd42, 32'hFFFF_FFFB,  1'b1, 1'b0, 6'd0},
      '{ACT_START, 6'd21, 32'hFFFF_FFFD,  1'b1, 1'b0, 6'd0},
      '{ACT_END,   6'd42, 32'hFFFF_FFFF,  1'b1, 1'b1, 6'd42},
      '{ACT_START, 6'd0,  32'd0,          1'b1, 1'b0, 6'd0},
      '{ACT_END,   6'd21, 32'd0,          1'b1, 1'b0, 6'd0},
      '{ACT_END,   6'd0,  32'hFFFF_FFFF,  1'b1, 1'b1, 6'd0}
   };

   logic              clock;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [39:0]       req_tdata = '0;   // event_id[5:0], event_time[37:6], zero[39:38]
   logic              req_tuser = 1'b0; // action
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [39:0]       rsp_tdata;        // expired_id[5:0], detected_at[37:6], zero[39:38]
   logic              rsp_tlast;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [SPAN_W-1:0] csr_data = '0;

   pending_type       outstanding[$];
   report_type        due_reports[$];
   report_type        got;
   logic [SPAN_W-1:0] span_now;
   logic [31:0]       stamp_now;
   int                idle_rate = 0;
   int                stall_left = 0;
   int                failures = 0;
   int                events_sent = 0;
   int                reports_seen = 0;
   int                spans_used = 0;
   int                longest_run = 0;

   request_timeout_tracker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic bit is_overdue(logic [31:0] stamp, logic [31:0] at);
      return at >= stamp && (at - stamp) > span_now;
   endfunction

   // Expire from the head, then apply the action; returns the number of reports.
   function automatic int apply_event(logic act, logic [ID_W-1:0] id, logic [31:0] at,
                                      bit record);
      int          n;
      int          k;
      report_type  rep;
      pending_type ent;
      n = 0;
      while (outstanding.size() != 0 && n < DEF_NUM_IDS &&
             is_overdue(outstanding[0].stamp, at)) begin
         if (record) begin
            rep = '{outstanding[0].id, at, 1'b0};
            due_reports.insert(due_reports.size(), rep);
         end
         outstanding.delete(0);
         n++;
      end
      if (record && n != 0) due_reports[due_reports.size()-1].last = 1'b1;
      for (k = 0; k < outstanding.size(); k++) begin
         if (outstanding[k].id == id) begin
            outstanding.delete(k);
            break;
         end
      end
      if (act == ACT_START) begin
         ent = '{id, at};
         outstanding.insert(outstanding.size(), ent);
      end
      return n;
   endfunction

   task automatic send_event(logic act, logic [ID_W-1:0] id, logic [31:0] at, bit record);
      int n;
      if (idle_rate != 0 && $urandom_range(0, 7) < idle_rate) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, at, id};
      req_tuser  <= act;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      n = apply_event(act, id, at, record);
      events_sent++;
      if (n > longest_run) longest_run = n;
   endtask

   // Hold the sender off until every report is in and the block has gone idle.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (due_reports.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_span(logic [SPAN_W-1:0] value);
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      span_now = value;
      spans_used++;
   endtask

   task automatic drain_list();
      while (outstanding.size() != 0)
         send_event(ACT_END, outstanding[0].id, stamp_now, 1'b1);
   endtask

   task automatic random_event(int pool, int unsigned step_max);
      int              r;
      logic            act;
      logic [ID_W-1:0] id;
      logic [31:0]     at;
      r = $urandom_range(0, 99);
      stamp_now += $urandom_range(0, step_max);
      at = stamp_now;
      if (r < 6 && stamp_now > 20) at = stamp_now - $urandom_range(1, 20);
      act = ACT_START;
      id  = ID_W'($urandom_range(0, pool));
      if (r >= 50 && r < 88 && outstanding.size() != 0) begin
         act = ACT_END;
         id  = outstanding[$urandom_range(0, outstanding.size() - 1)].id;
      end else if (r >= 88) begin
         act = ACT_END;
      end
      send_event(act, id, at, 1'b1);
   endtask

   always @(posedge clock) begin
      if (idle_rate == 0) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 15) < idle_rate) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 6);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         reports_seen++;
         if (due_reports.size() == 0) begin
            $error("unexpected beat: id %0d at %0d", rsp_tdata[5:0], rsp_tdata[37:6]);
            failures++;
         end else begin
            got = due_reports[0];
            due_reports.delete(0);
            if (rsp_tdata[5:0] !== got.id) begin
               $error("expired_id: expected %0d, got %0d", got.id, rsp_tdata[5:0]);
               failures++;
            end
            if (rsp_tdata[37:6] !== got.at) begin
               $error("detected_at: expected %0d, got %0d", got.at, rsp_tdata[37:6]);
               failures++;
            end
            if (rsp_tlast !== got.last) begin
               $error("last: expected %0d, got %0d", got.last, rsp_tlast);
               failures++;
            end
         end
      end
   end

   initial begin
      logic [ID_W-1:0] perm [DEF_NUM_IDS];
      logic [ID_W-1:0] swap;
      int              i;
      int              j;
      int              p;
      logic [31:0]     span_pick;
      report_type      typed_rep;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      span_now  = SPAN_RESET;
      idle_rate = 2;

      for (i = 0; i < NUM_ROWS; i++) begin
         send_event(DIRECTED_ROWS[i].act, DIRECTED_ROWS[i].id, DIRECTED_ROWS[i].at,
                    !DIRECTED_ROWS[i].typed);
         if (DIRECTED_ROWS[i].typed && DIRECTED_ROWS[i].hit) begin
            typed_rep = '{DIRECTED_ROWS[i].hit_id, DIRECTED_ROWS[i].at, 1'b1};
            due_reports.insert(due_reports.size(), typed_rep);
         end
      end
      stamp_now = 32'hFFFF_FFFF;
      drain_list();
      settle();

      // full list, then one event that expires every id
      write_span(32'd200);
      idle_rate = 5;
      for (i = 0; i < DEF_NUM_IDS; i++) perm[i] = i[ID_W-1:0];
      for (i = DEF_NUM_IDS - 1; i > 0; i--) begin
         j       = $urandom_range(0, i);
         swap    = perm[i];
         perm[i] = perm[j];
         perm[j] = swap;
      end
      stamp_now = 32'd1000;
      for (i = 0; i < DEF_NUM_IDS; i++) begin
         send_event(ACT_START, perm[i], stamp_now, 1'b1);
         stamp_now += $urandom_range(0, 1);
      end
      stamp_now += 500;
      send_event(ACT_END, ID_W'($urandom_range(0, 63)), stamp_now, 1'b1);

      for (p = 0; p < 7; p++) begin
         settle();
         case (p)
            0:       span_pick = 32'd0;
            1:       span_pick = 32'd1;
            2:       span_pick = 32'hFFFF_FFFF;
            3:       span_pick = 32'd5;
            4:       span_pick = 32'd200;
            5:       span_pick = $urandom_range(2, 60);
            default: span_pick = 32'd20;
         endcase
         write_span(span_pick);
         idle_rate = (p == 6) ? 0 : $urandom_range(0, 4);
         stamp_now = $urandom_range(0, 32'hF000_0000);
         for (i = 0; i < 30; i++)
            random_event((p % 2) ? 7 : 63, (span_pick < 1000) ? span_pick * 2 + 2 : 40);
         drain_list();
      end
      settle();

      $display("Covered %0d events under %0d timeout settings, %0d expiry beats checked",
               events_sent, spans_used + 1, reports_seen);
      $display("Longest expiry run from one event: %0d beats", longest_run);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
